// File: src/msb_pkg.sv
// Package: shared constants, types and register indexes for the masked sprite blitter.
`default_nettype none

package msb_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PIX_X_W       = $clog2(SCREEN_WIDTH);
  localparam int PIX_Y_W       = $clog2(SCREEN_HEIGHT);

  // Field widths
  localparam int ORIGIN_W = 16;
  localparam int DIM_W    = 8;
  localparam int BYTE_W   = 8;
  localparam int BIT_IDX_W = $clog2(BYTE_W);
  // Screen coordinate sum: signed origin plus unsigned count, one bit of headroom
  localparam int COORD_W  = ORIGIN_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ORIGIN_W;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 2'd3;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

  typedef struct packed {
    logic signed [ORIGIN_W-1:0] origin_x;
    logic signed [ORIGIN_W-1:0] origin_y;
    logic [DIM_W-1:0]           sprite_width;
    logic [DIM_W-1:0]           sprite_height;
  } cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0] column_count;
    logic [DIM_W-1:0] row_count;
  } cnt_t;

  typedef struct packed {
    logic               draw;
    logic [PIX_X_W-1:0] pixel_x;
    logic [PIX_Y_W-1:0] pixel_y;
    logic               colour;
    logic               last;
    logic               blit_done;
  } res_t;

endpackage

`default_nettype wire

// File: src/msb_if.sv
// Interfaces: byte-pair input channel and pixel result channel.
`default_nettype none

interface msb_in_if;
  logic                         valid;
  logic                         ready;
  logic [msb_pkg::BYTE_W-1:0]   sprite_byte;
  logic [msb_pkg::BYTE_W-1:0]   mask_byte;
  logic                         first_byte;

  modport source (output valid, sprite_byte, mask_byte, first_byte, input ready);
  modport sink   (input valid, sprite_byte, mask_byte, first_byte, output ready);
endinterface

interface msb_out_if;
  logic                          valid;
  logic                          ready;
  logic                          draw;
  logic [msb_pkg::PIX_X_W-1:0]   pixel_x;
  logic [msb_pkg::PIX_Y_W-1:0]   pixel_y;
  logic                          colour;
  logic                          last;
  logic                          blit_done;

  modport source (output valid, draw, pixel_x, pixel_y, colour, last, blit_done,
                  input ready);
  modport sink   (input valid, draw, pixel_x, pixel_y, colour, last, blit_done,
                  output ready);
endinterface

`default_nettype wire

// File: src/msb_cfg_regs.sv
// Configuration register bank: origin and sprite geometry.
`default_nettype none

module msb_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [msb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [msb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output msb_pkg::cfg_t                         cfg
);

  msb_pkg::cfg_t cfg_r;

  // Register writes by index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x      <= '0;
      cfg_r.origin_y      <= '0;
      cfg_r.sprite_width  <= msb_pkg::DIM_RESET;
      cfg_r.sprite_height <= msb_pkg::DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msb_pkg::REG_ORIGIN_X:      cfg_r.origin_x      <= cfg_wdata[msb_pkg::ORIGIN_W-1:0];
        msb_pkg::REG_ORIGIN_Y:      cfg_r.origin_y      <= cfg_wdata[msb_pkg::ORIGIN_W-1:0];
        msb_pkg::REG_SPRITE_WIDTH:  cfg_r.sprite_width  <= cfg_wdata[msb_pkg::DIM_W-1:0];
        msb_pkg::REG_SPRITE_HEIGHT: cfg_r.sprite_height <= cfg_wdata[msb_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: src/msb_pixel_unit.sv
// Pixel unit: one bit of the stream to one result, plus the advanced counters.
`default_nettype none

module msb_pixel_unit (
  input  wire msb_pkg::cfg_t cfg,
  input  wire msb_pkg::cnt_t cnt,
  input  wire logic       sprite_bit,
  input  wire logic       mask_bit,
  input  wire logic       last_bit,
  output msb_pkg::cnt_t   cnt_nxt,
  output msb_pkg::res_t   res
);

  logic                                 covered;
  logic                                 covered_nxt;
  logic [msb_pkg::DIM_W:0]              col_inc;
  logic signed [msb_pkg::COORD_W-1:0]   px;
  logic signed [msb_pkg::COORD_W-1:0]   py;
  logic                                 on_screen;

  // Sprite coverage and screen coordinate
  always_comb begin
    covered = (cfg.sprite_width == '0) || (cnt.row_count >= cfg.sprite_height);
    px = msb_pkg::COORD_W'(cfg.origin_x)
       + $signed({1'b0, (msb_pkg::COORD_W-1)'(cnt.column_count)});
    py = msb_pkg::COORD_W'(cfg.origin_y)
       + $signed({1'b0, (msb_pkg::COORD_W-1)'(cnt.row_count)});
    on_screen = !px[msb_pkg::COORD_W-1] && !py[msb_pkg::COORD_W-1]
             && (px < msb_pkg::COORD_W'(msb_pkg::SCREEN_WIDTH))
             && (py < msb_pkg::COORD_W'(msb_pkg::SCREEN_HEIGHT));
  end

  // Counter advance, wrapping the column on the sprite width
  always_comb begin
    col_inc = {1'b0, cnt.column_count} + (msb_pkg::DIM_W+1)'(1);
    cnt_nxt = cnt;
    if (!covered) begin
      if (col_inc >= {1'b0, cfg.sprite_width}) begin
        cnt_nxt.column_count = '0;
        cnt_nxt.row_count    = cnt.row_count + msb_pkg::DIM_W'(1);
      end else begin
        cnt_nxt.column_count = col_inc[msb_pkg::DIM_W-1:0];
      end
    end
    covered_nxt = (cfg.sprite_width == '0) || (cnt_nxt.row_count >= cfg.sprite_height);
  end

  // Result fields; no-draw results carry zero coordinates and colour
  always_comb begin
    res.draw      = !covered && mask_bit && on_screen;
    res.pixel_x   = res.draw ? px[msb_pkg::PIX_X_W-1:0] : '0;
    res.pixel_y   = res.draw ? py[msb_pkg::PIX_Y_W-1:0] : '0;
    res.colour    = res.draw && sprite_bit;
    res.last      = last_bit;
    res.blit_done = covered_nxt;
  end

endmodule

`default_nettype wire

// File: src/masked_sprite_blitter.sv
// Top level: byte holding register, bit serializer, pixel unit and result register.
// Path: a byte accepted into the holding register is serialized MSB first, and each
// bit's result is registered in the result register. Throughput: one result per
// cycle while the result channel does not stall; the next byte is taken on the cycle
// its predecessor's last bit moves into the result register.
// Reset (rst_n low, synchronous): both channels empty, counters zero, origins zero,
// width and height eight.
`default_nettype none

module masked_sprite_blitter (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  msb_in_if.sink                                in_ch,
  msb_out_if.source                             out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [msb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [msb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  msb_pkg::cfg_t cfg;

  logic                              hold_v_r;
  logic [msb_pkg::BYTE_W-1:0]        sprite_r;
  logic [msb_pkg::BYTE_W-1:0]        mask_r;
  logic                              first_r;
  logic [msb_pkg::BIT_IDX_W-1:0]     bit_idx_r;
  msb_pkg::cnt_t                     cnt_r;
  msb_pkg::cnt_t                     cnt_cur;
  msb_pkg::cnt_t                     cnt_nxt;
  logic                              out_v_r;
  msb_pkg::res_t                     res_r;
  msb_pkg::res_t                     res_nxt;
  logic                              last_bit;
  logic                              advance;
  logic                              in_xfer;
  logic [msb_pkg::BIT_IDX_W-1:0]     bit_sel;

  msb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Bit selection, MSB first; first byte clears counters before its first bit
  assign last_bit = (bit_idx_r == msb_pkg::BIT_IDX_W'(msb_pkg::BYTE_W - 1));
  assign bit_sel  = msb_pkg::BIT_IDX_W'(msb_pkg::BYTE_W - 1) - bit_idx_r;
  assign cnt_cur  = (first_r && (bit_idx_r == '0)) ? '0 : cnt_r;

  msb_pixel_unit u_pix (
    .cfg        (cfg),
    .cnt        (cnt_cur),
    .sprite_bit (sprite_r[bit_sel]),
    .mask_bit   (mask_r[bit_sel]),
    .last_bit   (last_bit),
    .cnt_nxt    (cnt_nxt),
    .res        (res_nxt)
  );

  // Handshake control
  assign advance      = hold_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !hold_v_r || (advance && last_bit);
  assign in_xfer      = in_ch.valid && in_ch.ready;

  // Holding register and bit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r  <= 1'b0;
      bit_idx_r <= '0;
      cnt_r     <= '0;
    end else begin
      if (advance) begin
        cnt_r <= cnt_nxt;
      end
      if (in_xfer) begin
        hold_v_r  <= 1'b1;
        bit_idx_r <= '0;
      end else if (advance) begin
        bit_idx_r <= bit_idx_r + msb_pkg::BIT_IDX_W'(1);
        if (last_bit) begin
          hold_v_r <= 1'b0;
        end
      end
    end
  end

  // Payload of the holding register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sprite_r <= in_ch.sprite_byte;
      mask_r   <= in_ch.mask_byte;
      first_r  <= in_ch.first_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.draw      = res_r.draw;
  assign out_ch.pixel_x   = res_r.pixel_x;
  assign out_ch.pixel_y   = res_r.pixel_y;
  assign out_ch.colour    = res_r.colour;
  assign out_ch.last      = res_r.last;
  assign out_ch.blit_done = res_r.blit_done;

endmodule

`default_nettype wire
